/* design/ahcpp_pkg.sv */
// Shared types, codes and command tables of the ASCII hex command packet parser.
package ahcpp_pkg;

  localparam int TokenBufferSizeDef = 10;
  localparam int FieldLimitDef      = 10;
  localparam int ArgSlots           = 9;
  localparam int NumCmds            = 8;
  localparam int TdataW             = 88;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TYPE,
    PH_FIELD
  } phase_t;

  typedef enum logic [2:0] {
    ERR_BAD_CHAR,
    ERR_NO_TYPE,
    ERR_NO_FIELD,
    ERR_UNKNOWN_TYPE,
    ERR_TOO_MANY,
    ERR_BAD_VALUE,
    ERR_COUNT,
    ERR_TOO_LONG
  } err_t;

  typedef enum logic [3:0] {
    CMD_TIME     = 4'd0,
    CMD_DATE     = 4'd1,
    CMD_SCHSET   = 4'd2,
    CMD_SCHINTEN = 4'd3,
    CMD_SCHINT   = 4'd4,
    CMD_SCHSEG   = 4'd5,
    CMD_OUTPUT   = 4'd6,
    CMD_SAVE     = 4'd7,
    CMD_NONE     = 4'd8
  } cmd_t;

  // Names right-aligned: first character in the highest used byte
  localparam logic [63:0] CMD_NAME [NumCmds] = '{
    64'("TIME"), 64'("DATE"), 64'("SCHSET"), 64'("SCHINTEN"),
    64'("SCHINT"), 64'("SCHSEG"), 64'("OUTPUT"), 64'("SAVE")
  };
  localparam logic [3:0] CMD_NAME_LEN [NumCmds] = '{
    4'd4, 4'd4, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd4
  };
  localparam logic [3:0] CMD_FIELDS [NumCmds] = '{
    4'd4, 4'd3, 4'd1, 4'd2, 4'd9, 4'd6, 4'd1, 4'd0
  };

  // Field limits
  localparam logic [15:0] YEAR_MIN   = 16'd2024;
  localparam logic [15:0] HOUR_MAX   = 16'd23;
  localparam logic [15:0] MINSEC_MAX = 16'd59;
  localparam logic [15:0] ZONE_MAX   = 16'h6F;
  localparam logic [15:0] MONTH_LIM  = 16'h0C;
  localparam logic [15:0] DAY_LIM    = 16'h1F;
  localparam logic [15:0] SW_HOUR_MAX = 16'h17;
  localparam logic [15:0] SW_MIN_MAX  = 16'h3C;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // One answer of the parser
  typedef struct packed {
    logic        is_error;
    err_t        error_code;
    logic [2:0]  command;
    logic [15:0] arg0;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    logic [7:0]  arg3;
    logic [7:0]  arg4;
    logic [7:0]  arg5;
    logic [7:0]  arg6;
    logic [7:0]  arg7;
    logic [7:0]  arg8;
  } res_t;

endpackage

/* design/ascii_hex_command_packet_parser.sv */
// Top level of the ASCII hex command packet parser.
// Parses packets "*TYPE;" or "*TYPE:F1:...:FN;" one received character per
// transfer and answers OK with command and hex arguments, or an error code.
// Input: s_axis_tdata carries one character. Output: m_axis_tuser flags an
// error answer, m_axis_tdata carries code, command and arguments.
// Characters that close no packet and cause no error give no answer.
// A character taken into the input register is parsed once the result
// register or its skid stage can accept, and any answer it gives lands in
// the result register, which drives m_axis_tvalid. One character per cycle
// is sustained while the skid stage is not full;
// the parser state update of one character is the state feedback loop.
// When the receiver stalls, answers collect in the result register and its
// skid stage; the input register and then s_axis_tready hold only when both
// are full.
// Reset (rst, synchronous) returns the parser to idle, awaiting '*', and
// clears the input, result and skid valid flags; no clearing pass is needed.
module ascii_hex_command_packet_parser import ahcpp_pkg::*; #(
  parameter int TOKEN_BUFFER_SIZE = TokenBufferSizeDef,
  parameter int FIELD_LIMIT       = FieldLimitDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,   // error_code, command, arg0..arg8, pad
  output logic              m_axis_tuser    // [0] is_error
);

  logic       in_valid, go, res_ready, res_valid;
  logic [7:0] in_byte;
  res_t       res, out_res;

  assign go            = in_valid && res_ready;
  assign s_axis_tready = !in_valid || go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_axis_tready) in_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_byte <= s_axis_tdata;
  end

  ahcpp_core #(
    .TOKEN_BUFFER_SIZE(TOKEN_BUFFER_SIZE),
    .FIELD_LIMIT      (FIELD_LIMIT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .rx_byte  (in_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  ahcpp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .push_ready(res_ready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  // Pack the answer, first field lowest
  assign m_axis_tuser = out_res.is_error;
  assign m_axis_tdata = {2'b00, out_res.arg8, out_res.arg7, out_res.arg6, out_res.arg5,
                         out_res.arg4, out_res.arg3, out_res.arg2, out_res.arg1,
                         out_res.arg0, out_res.command, out_res.error_code};

endmodule

/* design/ahcpp_core.sv */
// Parser state, token buffer, field decode and range checks.
module ahcpp_core import ahcpp_pkg::*; #(
  parameter int TOKEN_BUFFER_SIZE = TokenBufferSizeDef,
  parameter int FIELD_LIMIT       = FieldLimitDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  localparam int TokDepth = TOKEN_BUFFER_SIZE - 1;
  localparam int TokIdxW  = $clog2(TokDepth);
  localparam int LenW     = $clog2(TOKEN_BUFFER_SIZE);
  localparam int FcW      = $clog2(FIELD_LIMIT);
  localparam int RestIdxW = $clog2(ArgSlots - 1);

  phase_t          phase, phase_next;
  logic [LenW-1:0] len, len_next;
  cmd_t            cmd, cmd_next;
  logic [FcW-1:0]  fc, fc_next;
  logic [7:0]      tok [TokDepth];
  logic [15:0]     arg_first;
  logic [7:0]      arg_rest [ArgSlots-1];

  logic        tok_we, arg_we, emit, emit_ok, ok;
  err_t        err;
  logic [15:0] val;
  logic [3:0]  nib [4];
  logic [3:0]  nvalid;
  logic        hex2_ok, hex4_ok, first_ok, chk;
  logic        use_nib;
  logic [15:0] fval;
  logic        hit;
  cmd_t        hit_cmd;
  logic [3:0]  fc4;
  cmd_t        fin_cmd;
  logic [3:0]  fin_fc;
  logic        is_legal;
  logic [FcW:0] fc_inc;

  function automatic logic [4:0] nib_dec(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  // Hex decode of the first four buffered characters
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      {nvalid[i], nib[i]} = nib_dec(tok[i]);
    end
    hex2_ok  = (len == LenW'(1) && nvalid[0]) ||
               (len == LenW'(2) && nvalid[0] && nvalid[1]);
    hex4_ok  = hex2_ok || (len == LenW'(3) && &nvalid[2:0]) ||
               (len == LenW'(4) && &nvalid);
    first_ok = nvalid[0];
    unique case (len)
      LenW'(1): val = {12'd0, nib[0]};
      LenW'(2): val = {8'd0, nib[0], nib[1]};
      LenW'(3): val = {4'd0, nib[0], nib[1], nib[2]};
      default:  val = {nib[0], nib[1], nib[2], nib[3]};
    endcase
  end

  // Type name compare against the command table
  always_comb begin
    logic m;
    hit     = 1'b0;
    hit_cmd = CMD_NONE;
    for (int i = NumCmds - 1; i >= 0; i--) begin
      m = (len == LenW'(CMD_NAME_LEN[i]));
      for (int j = 0; j < 8; j++) begin
        if (j < int'(CMD_NAME_LEN[i]) &&
            tok[j] != CMD_NAME[i][8*(int'(CMD_NAME_LEN[i]) - 1 - j) +: 8]) begin
          m = 1'b0;
        end
      end
      if (m) begin
        hit     = 1'b1;
        hit_cmd = cmd_t'(4'(i));
      end
    end
  end

  // Range check of the field at the current position
  always_comb begin
    fc4     = 4'(fc);
    chk     = 1'b0;
    use_nib = 1'b0;
    unique case (cmd)
      CMD_TIME: begin
        if (fc4 == 4'd0) chk = hex2_ok && val <= HOUR_MAX;
        else if (fc4 == 4'd1 || fc4 == 4'd2) chk = hex2_ok && val <= MINSEC_MAX;
        else if (fc4 == 4'd3) chk = hex2_ok && val <= ZONE_MAX;
      end
      CMD_DATE: begin
        if (fc4 == 4'd0) chk = hex4_ok && val >= YEAR_MIN;
        else if (fc4 == 4'd1) begin
          chk     = first_ok && {12'd0, nib[0]} < MONTH_LIM;
          use_nib = 1'b1;
        end
        else if (fc4 == 4'd2) chk = hex2_ok && val < DAY_LIM;
      end
      CMD_SCHSET: begin
        chk     = fc4 == 4'd0 && first_ok && nib[0] <= 4'd2;
        use_nib = 1'b1;
      end
      CMD_SCHINTEN: begin
        if (fc4 == 4'd0) chk = hex2_ok && val <= 16'd7;
        else if (fc4 == 4'd1) begin
          chk     = first_ok && nib[0] <= 4'd1;
          use_nib = 1'b1;
        end
      end
      CMD_SCHINT: begin
        unique case (fc4)
          4'd0: begin
            chk     = first_ok && nib[0] <= 4'd7;
            use_nib = 1'b1;
          end
          4'd1, 4'd5: begin
            chk     = first_ok && nib[0] <= 4'd2;
            use_nib = 1'b1;
          end
          4'd2, 4'd6: begin
            chk     = first_ok && nib[0] <= 4'd8;
            use_nib = 1'b1;
          end
          4'd3, 4'd7: chk = hex2_ok && val <= SW_HOUR_MAX;
          4'd4, 4'd8: chk = hex2_ok && val <= SW_MIN_MAX;
          default:    chk = 1'b0;
        endcase
      end
      CMD_SCHSEG: chk = fc4 <= 4'd5 && hex2_ok;
      CMD_OUTPUT: begin
        chk     = fc4 == 4'd0 && first_ok && nib[0] <= 4'd1;
        use_nib = 1'b1;
      end
      default:    chk = 1'b0;
    endcase
    // nibble fields keep only their leading digit
    fval = use_nib ? {12'd0, nib[0]} : val;
  end

  // Next state and answer for the byte in hand
  always_comb begin
    phase_next = phase;
    len_next   = len;
    cmd_next   = cmd;
    fc_next    = fc;
    tok_we     = 1'b0;
    arg_we     = 1'b0;
    emit       = 1'b0;
    emit_ok    = 1'b0;
    err        = ERR_BAD_CHAR;
    ok         = 1'b0;
    fc_inc     = {1'b0, fc} + (FcW+1)'(1);
    is_legal   = rx_byte == CH_STAR || rx_byte == CH_COLON || rx_byte == CH_SEMI ||
                 (rx_byte >= 8'h30 && rx_byte <= 8'h39) ||
                 (rx_byte >= 8'h41 && rx_byte <= 8'h5A);
    fin_cmd    = cmd;
    fin_fc     = 4'(fc);
    if (phase == PH_IDLE) begin
      len_next = '0;
      cmd_next = CMD_NONE;
      if (rx_byte == CH_STAR) phase_next = PH_TYPE;
      else emit = 1'b1;
    end else if (!is_legal || rx_byte == CH_STAR) begin
      // bad character answers, a new start goes quiet
      emit = !is_legal;
      phase_next = PH_IDLE;
      len_next   = '0;
      cmd_next   = CMD_NONE;
    end else if (rx_byte == CH_COLON || rx_byte == CH_SEMI) begin
      if (len == '0) begin
        err = (phase == PH_TYPE) ? ERR_NO_TYPE : ERR_NO_FIELD;
      end else if (phase == PH_TYPE) begin
        if (hit) begin
          ok       = 1'b1;
          cmd_next = hit_cmd;
          fc_next  = '0;
          fin_cmd  = hit_cmd;
          fin_fc   = 4'd0;
        end else begin
          err = ERR_UNKNOWN_TYPE;
        end
      end else begin
        if (fc_inc >= (FcW+1)'(FIELD_LIMIT)) err = ERR_TOO_MANY;
        else if (cmd == CMD_NONE || !chk) err = ERR_BAD_VALUE;
        else begin
          ok      = 1'b1;
          arg_we  = fc4 < 4'(ArgSlots);
          fc_next = fc_inc[FcW-1:0];
          fin_fc  = 4'(fc_inc);
        end
      end
      if (ok && rx_byte == CH_COLON) begin
        phase_next = PH_FIELD;
        len_next   = '0;
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
        len_next   = '0;
        cmd_next   = CMD_NONE;
        if (ok) begin
          if (fin_fc != CMD_FIELDS[fin_cmd[2:0]]) err = ERR_COUNT;
          else emit_ok = 1'b1;
        end
      end
    end else if (len < LenW'(TOKEN_BUFFER_SIZE - 1)) begin
      tok_we   = 1'b1;
      len_next = len + LenW'(1);
    end else begin
      emit       = 1'b1;
      err        = ERR_TOO_LONG;
      phase_next = PH_IDLE;
      len_next   = '0;
      cmd_next   = CMD_NONE;
    end
  end

  // Answer assembly; arguments past the command's count read as zero
  always_comb begin
    logic [3:0]  nf;
    logic [15:0] a_first;
    logic [7:0]  a_rest [ArgSlots-1];
    nf      = CMD_FIELDS[fin_cmd[2:0]];
    a_first = arg_first;
    a_rest  = arg_rest;
    // the closing field is only stored at this edge, so take it from the decode
    if (arg_we) begin
      if (fc4 == 4'd0) a_first = fval;
      else a_rest[RestIdxW'(fc4 - 4'd1)] = fval[7:0];
    end
    res = '0;
    res_valid = go && emit;
    if (emit_ok) begin
      res.command = fin_cmd[2:0];
      if (nf > 4'd0) res.arg0 = a_first;
      if (nf > 4'd1) res.arg1 = a_rest[0];
      if (nf > 4'd2) res.arg2 = a_rest[1];
      if (nf > 4'd3) res.arg3 = a_rest[2];
      if (nf > 4'd4) res.arg4 = a_rest[3];
      if (nf > 4'd5) res.arg5 = a_rest[4];
      if (nf > 4'd6) res.arg6 = a_rest[5];
      if (nf > 4'd7) res.arg7 = a_rest[6];
      if (nf > 4'd8) res.arg8 = a_rest[7];
    end else begin
      res.is_error   = 1'b1;
      res.error_code = err;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      len   <= '0;
      cmd   <= CMD_NONE;
      fc    <= '0;
    end else if (go) begin
      phase <= phase_next;
      len   <= len_next;
      cmd   <= cmd_next;
      fc    <= fc_next;
    end
  end

  // Token and argument stores
  always_ff @(posedge clk) begin
    if (go && tok_we) tok[len[TokIdxW-1:0]] <= rx_byte;
    if (go && arg_we) begin
      if (fc4 == 4'd0) arg_first <= fval;
      else arg_rest[RestIdxW'(fc4 - 4'd1)] <= fval[7:0];
    end
  end

endmodule

/* design/ahcpp_outbuf.sv */
// Result register with a skid stage towards the output channel.
module ahcpp_outbuf import ahcpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  output logic out_valid,
  output res_t out_data,
  input  logic out_ready
);

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic take;

  assign take       = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !main_valid) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take || !main_valid) main_data <= skid_valid ? skid_data : push_data;
    else if (push) skid_data <= push_data;
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid) else $error("skid full with output empty");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push) else $error("result pushed into full buffer");
  a_held_result_kept: assert property (@(posedge clk) disable iff (rst)
    main_valid && !out_ready |=> main_valid) else $error("stalled result lost");

endmodule
